>>> rtl/wlgsf_pkg.sv
package wlgsf_pkg;

    // field widths
    localparam int PIX_W  = 16;
    localparam int GRAY_W = 8;
    localparam int DEST_W = 24;
    localparam int DIM_W  = 13;

    // frame limits and counter widths
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    // divider: one quotient bit per step
    localparam int DIV_STEPS = GRAY_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [GRAY_W-1:0] GRAY_WHITE = '1;
    localparam logic [GRAY_W-1:0] GRAY_BLACK = '0;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd3;

    // register reset values
    localparam logic [PIX_W-1:0] LOW_RESET    = 16'sd0;
    localparam logic [PIX_W-1:0] HIGH_RESET   = 16'sd255;
    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(MAX_HEIGHT);

    // request to the shared divider
    typedef struct packed {
        logic             start;
        logic [PIX_W-1:0] num;
        logic [PIX_W-1:0] den;
    } div_req_t;

    // zero acts as one, anything above the limit acts as the limit
    function automatic logic [DIM_W-1:0] clamp_dim(
        input logic [DIM_W-1:0] v,
        input logic [DIM_W-1:0] maxv
    );
        logic [DIM_W-1:0] r;
        begin
            r = v;
            if (v == '0)
            begin
                r = DIM_W'(1);
            end
            else if (v > maxv)
            begin
                r = maxv;
            end
            return r;
        end
    endfunction

endpackage

>>> rtl/wlgsf_divider.sv
module wlgsf_divider (
    input  logic                           clk,
    input  logic                           rst_n,
    input  wlgsf_pkg::div_req_t            req,
    output logic                           done,
    output logic [wlgsf_pkg::GRAY_W-1:0]   quotient
);
    import wlgsf_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [PIX_W-1:0]  rem_reg;
    logic [PIX_W-1:0]  den_reg;
    logic [GRAY_W-1:0] quo_reg;

    logic [PIX_W:0]    shifted;
    logic [PIX_W+1:0]  trial;

    // restoring step: remainder stays below the divisor
    always_comb
    begin
        shifted = {rem_reg, 1'b0};
        trial   = {1'b0, shifted} - {2'b00, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(DIV_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.num;
            den_reg <= req.den;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (!trial[PIX_W+1])
            begin
                rem_reg <= trial[PIX_W-1:0];
                quo_reg <= {quo_reg[GRAY_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[PIX_W-1:0];
                quo_reg <= {quo_reg[GRAY_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/window_level_gray_stretch_flip_top.sv
// window/level gray stretch with a vertically flipped destination address
//
// input channel: pixel with in_valid / in_ready, raster order, rows first.
// output channel: gray, dest_index, frame_end with out_valid / out_ready,
// exactly one output transaction per input transaction, in order.
// config port: cfg_we, cfg_index / cfg_data (low, high, width, height);
// the user writes only while no pixel is in flight, unchecked by the block.
//
// timing: an input transaction is taken, then a setup state, eight
// steps of the shared restoring divider (one quotient bit per step) and
// a hand-off through the done state to the output register. in_ready
// comes back only when that result leaves the done state, so a pixel
// is not taken before the one ahead of it has been through the divider.
// the output register holds a finished result while the receiver stalls,
// and the next pixel may already be accepted and worked on meanwhile;
// a second finished result waits in the last state until the output
// register is free.
// reset: thresholds return to 0 / 255, width and height to 4096, the
// column and row counters to zero, no output is pending.
module window_level_gray_stretch_flip_top (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_we,
    input  logic [wlgsf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wlgsf_pkg::PIX_W-1:0]       cfg_data,
    // pixel input
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [wlgsf_pkg::PIX_W-1:0] pixel,
    // result output
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [wlgsf_pkg::GRAY_W-1:0]      gray,
    output logic [wlgsf_pkg::DEST_W-1:0]      dest_index,
    output logic                              frame_end
);
    import wlgsf_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SETUP = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic signed [PIX_W-1:0] low_reg;
    logic signed [PIX_W-1:0] high_reg;
    logic [DIM_W-1:0]        width_reg;
    logic [DIM_W-1:0]        height_reg;

    // frame position of the next pixel
    logic [COL_W-1:0] col_count_reg;
    logic [ROW_W-1:0] row_count_reg;

    // per-pixel work registers
    logic signed [PIX_W-1:0] pix_reg;
    logic [COL_W-1:0]        col_reg;
    logic [ROW_W-1:0]        flip_reg;
    logic                    fend_reg;
    logic                    white_reg;
    logic                    black_reg;
    logic [DEST_W-1:0]       prod_reg;

    // output register
    logic                    out_valid_reg;
    logic [GRAY_W-1:0]       gray_reg;
    logic [DEST_W-1:0]       dest_reg;
    logic                    frame_end_reg;

    logic [DIM_W-1:0]  w_eff;
    logic [DIM_W-1:0]  h_eff;
    logic [COL_W-1:0]  w_m1;
    logic [ROW_W-1:0]  h_m1;
    logic              row_end;
    logic              last_pix;
    logic [ROW_W-1:0]  flip_row;
    logic              in_take;
    logic              out_load;
    logic [PIX_W:0]    num_wide;
    logic [PIX_W:0]    den_wide;
    logic [COL_W+DIM_W-1:0] prod_full;
    logic [GRAY_W-1:0] gray_sel;

    div_req_t          div_req;
    logic              div_done;
    logic [GRAY_W-1:0] div_quo;

    // ---------------------------------------------------------------
    // frame geometry: out-of-range sizes are clamped, a counter past
    // the size closes the row or frame, and the flipped row is 0 then
    // ---------------------------------------------------------------
    always_comb
    begin
        w_eff    = clamp_dim(width_reg, DIM_W'(MAX_WIDTH));
        h_eff    = clamp_dim(height_reg, DIM_W'(MAX_HEIGHT));
        w_m1     = COL_W'(w_eff - DIM_W'(1));
        h_m1     = ROW_W'(h_eff - DIM_W'(1));
        row_end  = (col_count_reg >= w_m1);
        last_pix = row_end && (row_count_reg >= h_m1);
        flip_row = (row_count_reg <= h_m1) ? (h_m1 - row_count_reg) : '0;
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign in_take  = in_valid && in_ready;

    // output register is free, or its transaction completes this cycle
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ---------------------------------------------------------------
    // configuration writes
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg    <= LOW_RESET;
            high_reg   <= HIGH_RESET;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LOW:    low_reg    <= cfg_data;
                CFG_HIGH:   high_reg   <= cfg_data;
                CFG_WIDTH:  width_reg  <= cfg_data[DIM_W-1:0];
                CFG_HEIGHT: height_reg <= cfg_data[DIM_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // position counters advance on every accepted pixel
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else if (in_take)
        begin
            if (row_end)
            begin
                col_count_reg <= '0;
                row_count_reg <= last_pix ? '0 : row_count_reg + ROW_W'(1);
            end
            else
            begin
                col_count_reg <= col_count_reg + COL_W'(1);
            end
        end
    end

    // ---------------------------------------------------------------
    // setup: window tests, divider operands, row offset multiply
    // ---------------------------------------------------------------
    always_comb
    begin
        num_wide  = {pix_reg[PIX_W-1], pix_reg} - {low_reg[PIX_W-1], low_reg};
        den_wide  = {high_reg[PIX_W-1], high_reg} - {low_reg[PIX_W-1], low_reg};
        prod_full = (COL_W+DIM_W)'(flip_reg) * (COL_W+DIM_W)'(w_eff);

        div_req.start = (state_reg == ST_SETUP);
        div_req.num   = num_wide[PIX_W-1:0];
        div_req.den   = den_wide[PIX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            pix_reg  <= pixel;
            col_reg  <= col_count_reg;
            flip_reg <= flip_row;
            fend_reg <= last_pix;
        end
        if (state_reg == ST_SETUP)
        begin
            // white test wins when the thresholds cross
            white_reg <= (pix_reg >= high_reg);
            black_reg <= (pix_reg <= low_reg);
            prod_reg  <= prod_full[DEST_W-1:0];
        end
    end

    // shared divider: floor(256 * (pixel - low) / (high - low))
    wlgsf_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quo)
    );

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    always_comb
    begin
        if (white_reg)
        begin
            gray_sel = GRAY_WHITE;
        end
        else if (black_reg)
        begin
            gray_sel = GRAY_BLACK;
        end
        else
        begin
            gray_sel = div_quo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            gray_reg      <= gray_sel;
            dest_reg      <= prod_reg + DEST_W'(col_reg);
            frame_end_reg <= fend_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign gray       = gray_reg;
    assign dest_index = dest_reg;
    assign frame_end  = frame_end_reg;

endmodule

>>> tb/sv/window_level_gray_stretch_flip_top_tb.sv
module window_level_gray_stretch_flip_top_tb;

    import wlgsf_pkg::*;

    // one predicted output transaction
    typedef struct packed {
        logic [GRAY_W-1:0] gray;
        logic [DEST_W-1:0] dest;
        logic              last;
    } gray_result_t;

    // clock, reset and every block input start from a known value
    logic                    clk        = 1'b0;
    logic                    rst_n      = 1'b0;
    logic                    cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index  = CFG_LOW;
    logic [PIX_W-1:0]        cfg_data   = '0;
    logic                    in_valid   = 1'b0;
    logic signed [PIX_W-1:0] pixel      = '0;
    logic                    out_ready  = 1'b0;
    logic                    in_ready;
    logic                    out_valid;
    logic [GRAY_W-1:0]       gray;
    logic [DEST_W-1:0]       dest_index;
    logic                    frame_end;

    // shadow copy of the block registers and raster position, reset values
    logic [PIX_W-1:0]        low_thr    = LOW_RESET;
    logic [PIX_W-1:0]        high_thr   = HIGH_RESET;
    logic [DIM_W-1:0]        width_reg  = WIDTH_RESET;
    logic [DIM_W-1:0]        height_reg = HEIGHT_RESET;
    int                      col_pos    = 0;
    int                      row_pos    = 0;

    // predicted results in order of acceptance
    gray_result_t            pending_gray_results[$];

    // idling control, switched per phase of the random test
    logic                    sender_gaps_on     = 1'b1;
    logic                    receiver_stalls_on = 1'b1;

    // bookkeeping for the summary and the verdict
    int                      error_count     = 0;
    int                      sent_count      = 0;
    int                      checked_count   = 0;
    int                      frame_end_count = 0;
    int                      cfg_write_count = 0;

    window_level_gray_stretch_flip_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pixel      (pixel),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .gray       (gray),
        .dest_index (dest_index),
        .frame_end  (frame_end)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // run limit, far above the slowest legal run
    initial
    begin
        #(12 * 500000);
        $display("window_level_gray_stretch_flip_top_tb: FAIL");
        $finish;
    end

    // stretch one pixel through the window and place it in the flipped frame,
    // then advance the raster position like the block does
    function automatic gray_result_t stretch_and_address(input logic signed [PIX_W-1:0] value);
        gray_result_t r;
        int           w;
        int           h;
        int           lo;
        int           hi;
        int           p;
        int           flip_row;
        logic         row_done;
        begin
            // zero acts as one, anything past the limit acts as the limit
            w = int'(width_reg);
            h = int'(height_reg);
            if (w == 0)
            begin
                w = 1;
            end
            else if (w > MAX_WIDTH)
            begin
                w = MAX_WIDTH;
            end
            if (h == 0)
            begin
                h = 1;
            end
            else if (h > MAX_HEIGHT)
            begin
                h = MAX_HEIGHT;
            end

            // white test comes first, so crossed thresholds never divide
            lo = int'($signed(low_thr));
            hi = int'($signed(high_thr));
            p  = int'(value);
            if (p >= hi)
            begin
                r.gray = GRAY_WHITE;
            end
            else if (p <= lo)
            begin
                r.gray = GRAY_BLACK;
            end
            else
            begin
                r.gray = GRAY_W'(((p - lo) * 256) / (hi - lo));
            end

            // a row past the current height maps to flipped row zero
            flip_row = (row_pos < h) ? (h - 1 - row_pos) : 0;
            r.dest   = DEST_W'(flip_row * w + col_pos);
            row_done = (col_pos >= w - 1);
            r.last   = row_done && (row_pos >= h - 1);

            if (row_done)
            begin
                col_pos = 0;
                row_pos = r.last ? 0 : row_pos + 1;
            end
            else
            begin
                col_pos = col_pos + 1;
            end
            return r;
        end
    endfunction

    function automatic logic signed [PIX_W-1:0] random_sample();
        return $signed(PIX_W'($urandom));
    endfunction

    // one pixel transaction; valid stays high afterwards so that a
    // back-to-back item needs no drop of valid
    task automatic send_pixel(input logic signed [PIX_W-1:0] value);
        int gap;
        begin
            gap = sender_gaps_on ? $urandom_range(0, 10) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid <= 1'b1;
            pixel    <= value;
            do
                @(posedge clk);
            while (!in_ready);
            pending_gray_results.push_back(stretch_and_address(value));
            sent_count++;
        end
    endtask

    // drop valid and hold the sender until every predicted result is out
    task automatic wait_results_drained();
        begin
            in_valid <= 1'b0;
            while (pending_gray_results.size() != 0) @(posedge clk);
            repeat (2) @(posedge clk);
        end
    endtask

    // single-cycle register write, only called while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PIX_W-1:0] data);
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= data;
            @(posedge clk);
            cfg_we <= 1'b0;
            case (idx)
                CFG_LOW:    low_thr    = data;
                CFG_HIGH:   high_thr   = data;
                CFG_WIDTH:  width_reg  = data[DIM_W-1:0];
                CFG_HEIGHT: height_reg = data[DIM_W-1:0];
                default:    ;
            endcase
            cfg_write_count++;
            // spare edge keeps the next write from landing in this step
            @(posedge clk);
        end
    endtask

    task automatic set_window(input int lo, input int hi);
        begin
            write_reg(CFG_LOW, PIX_W'(lo));
            write_reg(CFG_HIGH, PIX_W'(hi));
        end
    endtask

    task automatic set_frame(input int w, input int h);
        begin
            write_reg(CFG_WIDTH, PIX_W'(w));
            write_reg(CFG_HEIGHT, PIX_W'(h));
        end
    endtask

    // reset thresholds 0 / 255 and the 4096 x 4096 frame: addresses start
    // at the top of the 24-bit range
    task automatic test_reset_defaults();
        begin
            send_pixel(-16'sd32768);
            send_pixel(16'sd0);
            send_pixel(16'sd128);
            send_pixel(16'sd255);
            send_pixel(16'sd32767);
            wait_results_drained();
        end
    endtask

    // full span, equal thresholds and crossed thresholds
    task automatic test_threshold_edges();
        begin
            set_window(-32768, 32767);
            send_pixel(-16'sd32768);
            send_pixel(-16'sd32767);
            send_pixel(16'sd32766);
            send_pixel(16'sd32767);
            wait_results_drained();

            // equal: white at or above the threshold, black below, never a divide
            set_window(100, 100);
            send_pixel(16'sd99);
            send_pixel(16'sd100);
            send_pixel(16'sd101);
            wait_results_drained();

            // crossed: white at or above high, black for the rest
            set_window(500, -500);
            send_pixel(-16'sd500);
            send_pixel(16'sd499);
            send_pixel(16'sd500);
            wait_results_drained();
        end
    endtask

    // frame sizes: zero dims, a size cut in mid-frame, oversized dims
    task automatic test_frame_geometry();
        begin
            set_window(-1000, 1000);
            // zero width and height act as one: every pixel ends a frame
            set_frame(0, 0);
            send_pixel(16'sd0);
            send_pixel(16'sd999);
            wait_results_drained();

            set_frame(3, 2);
            send_pixel(-16'sd999);
            send_pixel(16'sd1);
            send_pixel(16'sd500);
            send_pixel(-16'sd1);
            wait_results_drained();

            // column and row now sit past the new 1 x 1 frame
            set_frame(1, 1);
            send_pixel(16'sd250);
            wait_results_drained();

            // 4096 exactly and a value far past the limit
            set_frame(4096, 16'hFFFF);
            send_pixel(16'sd750);
            wait_results_drained();
        end
    endtask

    // phases of random settings and pixels, mostly small frames so that
    // frame ends come often
    task automatic test_random_frames(input int target_items);
        int                      done_items;
        int                      phase_no;
        int                      phase_len;
        int                      sel;
        int                      a;
        int                      b;
        int                      lo;
        int                      hi;
        int                      kind;
        int                      k;
        logic signed [PIX_W-1:0] value;
        begin
            done_items = 0;
            phase_no   = 0;
            while (done_items < target_items)
            begin
                // window setting
                a   = int'(random_sample());
                b   = int'(random_sample());
                sel = $urandom_range(0, 9);
                case (sel)
                    0:
                    begin
                        lo = -32768;
                        hi = 32767;
                    end
                    1:
                    begin
                        lo = a;
                        hi = a;
                    end
                    2:
                    begin
                        lo = (a > b) ? a : b;
                        hi = (a > b) ? b : a;
                    end
                    3:
                    begin
                        lo = a;
                        hi = a + $urandom_range(1, 16);
                        if (hi > 32767)
                        begin
                            hi = 32767;
                        end
                    end
                    default:
                    begin
                        lo = (a < b) ? a : b;
                        hi = (a < b) ? b : a;
                    end
                endcase
                set_window(lo, hi);

                // frame setting; counters carry over from the last phase
                sel = $urandom_range(0, 7);
                if (sel == 0)
                begin
                    write_reg(CFG_WIDTH, PIX_W'($urandom));
                    write_reg(CFG_HEIGHT, PIX_W'($urandom));
                end
                else if (sel == 1)
                begin
                    set_frame(4096, $urandom_range(1, 3));
                end
                else
                begin
                    set_frame($urandom_range(1, 12), $urandom_range(1, 6));
                end

                sender_gaps_on     = ($urandom_range(0, 3) != 0);
                receiver_stalls_on = ($urandom_range(0, 3) != 0);
                phase_len          = $urandom_range(20, 70);

                for (k = 0; k < phase_len; k++)
                begin
                    kind = $urandom_range(0, 7);
                    if (kind <= 3 && lo < hi)
                    begin
                        value = PIX_W'(lo + $urandom_range(0, hi - lo));
                    end
                    else if (kind == 6)
                    begin
                        // right at or next to a threshold
                        a     = ($urandom_range(0, 1) != 0) ? lo : hi;
                        value = PIX_W'(a + $urandom_range(0, 2) - 1);
                    end
                    else if (kind == 7)
                    begin
                        value = ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
                    end
                    else
                    begin
                        value = random_sample();
                    end
                    send_pixel(value);

                    // sender holds off until the block has emptied
                    if (k == phase_len / 2 && (phase_no == 0 || $urandom_range(0, 2) == 0))
                    begin
                        wait_results_drained();
                    end
                end
                done_items += phase_len;
                phase_no++;
                wait_results_drained();
            end
        end
    endtask

    // receiver: random stall per result, then check against the oldest
    // prediction
    initial
    begin
        int           stall;
        gray_result_t want;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            stall = receiver_stalls_on ? $urandom_range(0, 10) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);

            if (pending_gray_results.size() == 0)
            begin
                $error("result transaction with nothing expected: gray %0d dest_index %0d",
                       gray, dest_index);
                error_count++;
            end
            else
            begin
                want = pending_gray_results.pop_front();
                if (gray !== want.gray)
                begin
                    $error("gray mismatch: expected %0d, actual %0d", want.gray, gray);
                    error_count++;
                end
                if (dest_index !== want.dest)
                begin
                    $error("dest_index mismatch: expected %0d, actual %0d",
                           want.dest, dest_index);
                    error_count++;
                end
                if (frame_end !== want.last)
                begin
                    $error("frame_end mismatch: expected %0b, actual %0b",
                           want.last, frame_end);
                    error_count++;
                end
                checked_count++;
                if (want.last)
                begin
                    frame_end_count++;
                end
            end
        end
    end

    // test sequence
    initial
    begin
        // reset released at a clock edge so no flop sees it mid-cycle
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_threshold_edges();
        test_frame_geometry();
        test_random_frames(900);

        wait_results_drained();
        repeat (20) @(posedge clk);

        $display("covered %0d pixel transactions and %0d checked results, %0d frame ends,",
                 sent_count, checked_count, frame_end_count);
        $display("over %0d register writes with idle and stalled stretches on both sides",
                 cfg_write_count);
        if (error_count == 0 && pending_gray_results.size() == 0)
        begin
            $display("window_level_gray_stretch_flip_top_tb: PASS");
        end
        else
        begin
            $display("window_level_gray_stretch_flip_top_tb: FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/wlgsf_pkg.sv
rtl/wlgsf_divider.sv
rtl/window_level_gray_stretch_flip_top.sv
tb/sv/window_level_gray_stretch_flip_top_tb.sv
